[sv/gsbb_pkg.sv]
// Package: shared types, constants and helpers for the splat bounding-box block.
`timescale 1ns / 1ps
`default_nettype none
package gsbb_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAT_FRAC        = 28;
    localparam int SQRT_STEPS      = 32;

    // One word handed from the front part to the back part through the queue.
    typedef struct packed {
        logic [2:0][63:0] sum;
        logic [2:0][31:0] centre;
        logic             last;
    } gsbb_item_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -37'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/gsbb_front.sv]
// Front part: rotation matrix, scaled magnitudes and per-row sums of squares.
`timescale 1ns / 1ps
`default_nettype none
module gsbb_front
    import gsbb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic signed [31:0] centre_x,
    input  wire logic signed [31:0] centre_y,
    input  wire logic signed [31:0] centre_z,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic [30:0]        scale_x,
    input  wire logic [30:0]        scale_y,
    input  wire logic [30:0]        scale_z,
    input  wire logic               last_splat,
    output logic                    push,
    output gsbb_item_t              item
);

    localparam logic signed [34:0] ONE = 35'sd1 <<< MAT_FRAC;

    logic [6:0] v_reg;

    // stage 0: captured word
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [30:0]        s0_reg [3];
    // carried fields
    logic [30:0]        s1_reg [3], s2_reg [3];
    logic [2:0][31:0]   c_reg [7];
    logic [6:0]         l_reg;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [33:0]        a_reg [3][3];
    logic [47:0]        lo_reg [3][3];
    logic [47:0]        hi_reg [3][3];
    logic [31:0]        m_reg [3][3];
    logic [63:0]        sq_reg [3][3];
    logic [2:0][63:0]   sum_reg;

    logic signed [34:0] r_c [3][3];
    logic [64:0]        full_c [3][3];
    logic [36:0]        mf_c [3][3];

    always_comb
    begin
        r_c[0][0] = ONE - ((35'(yy_reg) + 35'(zz_reg)) <<< 1);
        r_c[0][1] = (35'(xy_reg) - 35'(wz_reg)) <<< 1;
        r_c[0][2] = (35'(xz_reg) + 35'(wy_reg)) <<< 1;
        r_c[1][0] = (35'(xy_reg) + 35'(wz_reg)) <<< 1;
        r_c[1][1] = ONE - ((35'(xx_reg) + 35'(zz_reg)) <<< 1);
        r_c[1][2] = (35'(yz_reg) - 35'(wx_reg)) <<< 1;
        r_c[2][0] = (35'(xz_reg) - 35'(wy_reg)) <<< 1;
        r_c[2][1] = (35'(yz_reg) + 35'(wx_reg)) <<< 1;
        r_c[2][2] = ONE - ((35'(xx_reg) + 35'(yy_reg)) <<< 1);
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                full_c[j][k] = {hi_reg[j][k], 17'd0} + 65'(lo_reg[j][k])
                             + (65'd1 << (MAT_FRAC - 1));
                mf_c[j][k]   = full_c[j][k][MAT_FRAC +: 37];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[5:0], accept};
    end

    always_ff @(posedge clk)
    begin
        // stage 0
        qx_reg    <= quat_x;
        qy_reg    <= quat_y;
        qz_reg    <= quat_z;
        qw_reg    <= quat_w;
        s0_reg[0] <= scale_x;
        s0_reg[1] <= scale_y;
        s0_reg[2] <= scale_z;
        c_reg[0]  <= {centre_z, centre_y, centre_x};
        l_reg     <= {l_reg[5:0], last_splat};
        for (int i = 1; i < 7; i++)
            c_reg[i] <= c_reg[i-1];
        s1_reg <= s0_reg;
        s2_reg <= s1_reg;
        // stage 1: quaternion products
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;
        wy_reg <= qw_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // stage 2: matrix entry magnitude
                a_reg[j][k]  <= r_c[j][k][34] ? 34'(-r_c[j][k]) : r_c[j][k][33:0];
                // stage 3: split product with the scale
                lo_reg[j][k] <= 48'(a_reg[j][k][16:0]) * 48'(s2_reg[k]);
                hi_reg[j][k] <= 48'(a_reg[j][k][33:17]) * 48'(s2_reg[k]);
                // stage 4: round and cap
                m_reg[j][k]  <= (mf_c[j][k] > 37'h0_8000_0000) ? 32'h8000_0000
                                                               : mf_c[j][k][31:0];
                // stage 5: square
                sq_reg[j][k] <= 64'(m_reg[j][k]) * 64'(m_reg[j][k]);
            end
            // stage 6: row sum
            sum_reg[j] <= sq_reg[j][0] + sq_reg[j][1] + sq_reg[j][2];
        end
    end

    assign push        = v_reg[6];
    assign item.sum    = sum_reg;
    assign item.centre = c_reg[6];
    assign item.last   = l_reg[6];

endmodule
`default_nettype wire

[sv/gsbb_queue.sv]
// Queue: short FIFO that decouples the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module gsbb_queue
    import gsbb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire gsbb_item_t push_item,
    input  wire logic       pop,
    output logic            not_empty,
    output gsbb_item_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gsbb_item_t       mem [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;
    logic             head_v_reg;
    gsbb_item_t       head_reg;
    logic             load;

    // refill the head register from the array whenever it is free or leaving
    assign load = (cnt_reg != '0) && (!head_v_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg     <= '0;
            rd_reg     <= '0;
            cnt_reg    <= '0;
            head_v_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (load)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(push) - CW'(load);
            if (load)
                head_v_reg <= 1'b1;
            else if (pop)
                head_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
        if (load)
            head_reg <= mem[rd_reg];
    end

    assign not_empty = head_v_reg;
    assign head      = head_reg;

endmodule
`default_nettype wire

[sv/gsbb_back.sv]
// Back part: pipelined square roots, half extents and saturated corners.
`timescale 1ns / 1ps
`default_nettype none
module gsbb_back
    import gsbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        not_empty,
    input  wire gsbb_item_t  head,
    output logic             pop,
    output logic             box_valid,
    input  wire logic        box_stall,
    output logic signed [31:0] box_min_x,
    output logic signed [31:0] box_min_y,
    output logic signed [31:0] box_min_z,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic signed [31:0] box_max_z,
    output logic             last_box
);

    localparam int N = SQRT_STEPS;

    logic             adv;
    logic [N:0]       v_reg;
    logic [63:0]      rem_reg [N+1][3];
    logic [63:0]      res_reg [N+1][3];
    logic [2:0][31:0] c_reg   [N+1];
    logic [N:0]       l_reg;
    logic             out_v_reg;
    logic [2:0][31:0] lo_reg, hi_reg;
    logic             last_reg;

    logic [63:0]        rem_c [N][3];
    logic [63:0]        res_c [N][3];
    logic [32:0]        norm_c [3];
    logic [34:0]        half_c [3];
    logic signed [36:0] cw_c [3];

    // hold everything while the output word waits
    assign adv = !out_v_reg || !box_stall;
    assign pop = adv && not_empty;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (rem_reg[k][a] >= res_reg[k][a] + (64'd1 << (62 - 2*k)))
                begin
                    rem_c[k][a] = rem_reg[k][a] - (res_reg[k][a] + (64'd1 << (62 - 2*k)));
                    res_c[k][a] = (res_reg[k][a] >> 1) + (64'd1 << (62 - 2*k));
                end
                else
                begin
                    rem_c[k][a] = rem_reg[k][a];
                    res_c[k][a] = res_reg[k][a] >> 1;
                end
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            norm_c[a] = res_reg[N][a][32:0]
                      + 33'(rem_reg[N][a] > res_reg[N][a]);
            half_c[a] = {norm_c[a], 1'b0} + 35'(norm_c[a]);
            cw_c[a]   = 37'($signed(c_reg[N][a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[N-1:0], not_empty};
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[0][a] <= head.sum[a];
                res_reg[0][a] <= '0;
                for (int k = 0; k < N; k++)
                begin
                    rem_reg[k+1][a] <= rem_c[k][a];
                    res_reg[k+1][a] <= res_c[k][a];
                end
                lo_reg[a] <= sat32(cw_c[a] - 37'(half_c[a]));
                hi_reg[a] <= sat32(cw_c[a] + 37'(half_c[a]));
            end
            c_reg[0] <= head.centre;
            for (int k = 0; k < N; k++)
                c_reg[k+1] <= c_reg[k];
            l_reg    <= {l_reg[N-1:0], head.last};
            last_reg <= l_reg[N];
        end
    end

    assign box_valid = out_v_reg;
    assign box_min_x = lo_reg[0];
    assign box_min_y = lo_reg[1];
    assign box_min_z = lo_reg[2];
    assign box_max_x = hi_reg[0];
    assign box_max_y = hi_reg[1];
    assign box_max_z = hi_reg[2];
    assign last_box  = last_reg;

endmodule
`default_nettype wire

[sv/gaussian_splat_bounding_box.sv]
// Top level: 3-sigma axis-aligned bounding box of Gaussian splats.
//
//   channel | direction | handshake                | payload
//   splat   | in        | splat_valid / splat_stall| centre, quat, scale, last_splat
//   box     | out       | box_valid / box_stall    | box_min, box_max, last_box
//
// One word per cycle in and out when the output is not stalled.
// The data path runs through 7 front stages (capture, products, matrix,
// split multiply, rounding, squares, row sums), the queue (write,
// registered read), an input register, 32 square-root stages and the
// output register. The root pipeline resolves one result bit per stage.
// Reset clears all valid flags, queue pointers and the credit count.
// A stalled output holds the back part; the front keeps running until the
// queue credits (QUEUE_DEPTH words) are used up, then splat_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_splat_bounding_box
    import gsbb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               splat_valid,
    output logic                    splat_stall,
    input  wire logic signed [31:0] centre_x,
    input  wire logic signed [31:0] centre_y,
    input  wire logic signed [31:0] centre_z,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic [30:0]        scale_x,
    input  wire logic [30:0]        scale_y,
    input  wire logic [30:0]        scale_z,
    input  wire logic               last_splat,
    output logic                    box_valid,
    input  wire logic               box_stall,
    output logic signed [31:0]      box_min_x,
    output logic signed [31:0]      box_min_y,
    output logic signed [31:0]      box_min_z,
    output logic signed [31:0]      box_max_x,
    output logic signed [31:0]      box_max_y,
    output logic signed [31:0]      box_max_z,
    output logic                    last_box
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          accept, push, pop, not_empty;
    gsbb_item_t    push_item, head;
    logic [CW-1:0] credit_reg, credit_next;

    // Count words from acceptance until they leave the queue, so the
    // non-stalling front pipeline can never overrun the queue.
    assign splat_stall = (credit_reg == CW'(QUEUE_DEPTH));
    assign accept      = splat_valid && !splat_stall;
    assign credit_next = credit_reg + CW'(accept) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

    gsbb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .centre_z   (centre_z),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .scale_x    (scale_x),
        .scale_y    (scale_y),
        .scale_z    (scale_z),
        .last_splat (last_splat),
        .push       (push),
        .item       (push_item)
    );

    gsbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    gsbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .box_max_x (box_max_x),
        .box_max_y (box_max_y),
        .box_max_z (box_max_z),
        .last_box  (last_box)
    );

endmodule
`default_nettype wire

[tb/gaussian_splat_bounding_box_test.sv]
// Testbench for the Gaussian splat 3-sigma bounding-box block.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_splat_bounding_box_test;
    import gsbb_pkg::*;

    // One splat word as presented on the input channel.
    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic signed [15:0] qx, qy, qz, qw;
        logic [30:0]        sx, sy, sz;
        logic               last;
    } splat_t;

    // One box word as expected on the output channel.
    typedef struct {
        logic [31:0] mn [3];
        logic [31:0] mx [3];
        logic        last;
    } box_t;

    localparam longint CYCLE_LIMIT = 1_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic splat_valid = 1'b0;
    logic splat_stall;
    logic signed [31:0] centre_x = '0, centre_y = '0, centre_z = '0;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic [30:0] scale_x = '0, scale_y = '0, scale_z = '0;
    logic last_splat = 1'b0;
    logic box_valid;
    logic box_stall = 1'b0;
    logic signed [31:0] box_min_x, box_min_y, box_min_z;
    logic signed [31:0] box_max_x, box_max_y, box_max_z;
    logic last_box;

    box_t   pending_boxes [$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    longint cycles = 0;

    always #5 clk = ~clk;

    gaussian_splat_bounding_box dut (.*);

    // Square root of a 64-bit value rounded to nearest.
    function automatic logic [63:0] root_rounded(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (n > res)
            res = res + 1;
        return res;
    endfunction

    // |r| * s rounded to the coordinate format, capped at 2^31.
    function automatic logic [63:0] entry_mag(input longint r, input logic [30:0] s);
        logic [63:0] a;
        logic [63:0] m;
        a = (r < 0) ? -r : r;
        m = (a * {33'd0, s} + (64'd1 << (MAT_FRAC - 1))) >> MAT_FRAC;
        return (m > 64'h8000_0000) ? 64'h8000_0000 : m;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic box_t splat_box(input splat_t sp);
        box_t   b;
        longint qx, qy, qz, qw, one;
        longint rm [3][3];
        longint c [3];
        logic [30:0] s [3];
        logic [63:0] sum, m, half;
        qx = sp.qx; qy = sp.qy; qz = sp.qz; qw = sp.qw;
        one = 64'sd1 << MAT_FRAC;
        c[0] = sp.cx; c[1] = sp.cy; c[2] = sp.cz;
        s[0] = sp.sx; s[1] = sp.sy; s[2] = sp.sz;
        rm[0][0] = one - 2 * (qy * qy + qz * qz);
        rm[0][1] = 2 * (qx * qy - qw * qz);
        rm[0][2] = 2 * (qx * qz + qw * qy);
        rm[1][0] = 2 * (qx * qy + qw * qz);
        rm[1][1] = one - 2 * (qx * qx + qz * qz);
        rm[1][2] = 2 * (qy * qz - qw * qx);
        rm[2][0] = 2 * (qx * qz - qw * qy);
        rm[2][1] = 2 * (qy * qz + qw * qx);
        rm[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int j = 0; j < 3; j++)
        begin
            sum = '0;
            for (int k = 0; k < 3; k++)
            begin
                m = entry_mag(rm[j][k], s[k]);
                sum = sum + m * m;
            end
            half = root_rounded(sum) * 3;
            b.mn[j] = clamp32(c[j] - longint'(half));
            b.mx[j] = clamp32(c[j] + longint'(half));
        end
        b.last = sp.last;
        return b;
    endfunction

    // Present one word, hold it until accepted, then predict its box.
    // Valid stays high on return so words can follow back to back.
    task automatic send_splat(input splat_t sp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            splat_valid <= 1'b0;
            @(negedge clk);
        end
        splat_valid <= 1'b1;
        centre_x <= sp.cx; centre_y <= sp.cy; centre_z <= sp.cz;
        quat_x <= sp.qx; quat_y <= sp.qy; quat_z <= sp.qz; quat_w <= sp.qw;
        scale_x <= sp.sx; scale_y <= sp.sy; scale_z <= sp.sz;
        last_splat <= sp.last;
        do
            @(posedge clk);
        while (splat_stall);
        pending_boxes = {pending_boxes, splat_box(sp)};
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(3))
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [30:0] rand_scale();
        case ($urandom_range(4))
            0: return 31'($urandom_range(65536 * 16));
            1: return 31'($urandom);
            2: return '0;
            3: return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(65536 * 1024));
        endcase
    endfunction

    function automatic logic [31:0] rand_centre();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF - $urandom_range(1 << 20);
            1: return 32'h8000_0000 + $urandom_range(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic splat_t rand_splat();
        splat_t sp;
        sp.cx = rand_centre(); sp.cy = rand_centre(); sp.cz = rand_centre();
        sp.qx = rand_quat(); sp.qy = rand_quat(); sp.qz = rand_quat(); sp.qw = rand_quat();
        sp.sx = rand_scale(); sp.sy = rand_scale(); sp.sz = rand_scale();
        sp.last = $urandom_range(1);
        return sp;
    endfunction

    function automatic splat_t make_splat(input logic [31:0] c, input logic [15:0] qx,
        input logic [15:0] qy, input logic [15:0] qz, input logic [15:0] qw,
        input logic [30:0] s, input logic last);
        splat_t sp;
        sp.cx = c; sp.cy = -c; sp.cz = c ^ 32'h5555_AAAA;
        sp.qx = qx; sp.qy = qy; sp.qz = qz; sp.qw = qw;
        sp.sx = s; sp.sy = s >> 1; sp.sz = s ^ 31'h2AAA_5555;
        sp.last = last;
        return sp;
    endfunction

    // Directed words: identity, zero and non-unit quaternions, zero and
    // full scales, centres at both rails, last flag both ways.
    task automatic test_corner_splats();
        splat_t sp;
        send_splat(make_splat(32'h0001_0000, 0, 0, 0, 16'sd16384, 31'h0001_0000, 1'b0));
        send_splat(make_splat(32'h0, 0, 0, 0, 0, 31'h0003_0000, 1'b1));
        send_splat(make_splat(32'h7FFF_FFFF, 16'sd16384, 16'sd16384, 16'sd16384,
            16'sd16384, 31'h7FFF_FFFF, 1'b0));
        send_splat(make_splat(32'h8000_0000, -16'sd16384, -16'sd16384, -16'sd16384,
            -16'sd16384, 31'h7FFF_FFFF, 1'b1));
        send_splat(make_splat(32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            31'h7FFF_FFFF, 1'b0));
        send_splat(make_splat(32'h1234_5678, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            31'h0000_0001, 1'b1));
        send_splat(make_splat(32'hFFFF_FFFF, 16'sd11585, 0, 0, 16'sd11585, 31'h0002_0000, 1'b0));
        sp = make_splat(32'h4000_0000, 0, 16'sd11585, 0, 16'sd11585, 31'h0, 1'b1);
        send_splat(sp);
        sp.sx = 31'h7FFF_FFFF; sp.sy = 0; sp.sz = 0;
        send_splat(sp);
        sp = make_splat(32'h0, 16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 31'h0, 1'b0);
        send_splat(sp);
    endtask

    task automatic test_random_splats(input int count, input int idle_pct, input int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        repeat (count)
            send_splat(rand_splat());
        // drop valid, then drain
        splat_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_boxes.size() != 0);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Drive the output stall at the falling edge.
    always @(negedge clk)
        box_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Compare every accepted box with the oldest prediction.
    always @(posedge clk)
    begin
        box_t want;
        logic [31:0] got_mn [3];
        logic [31:0] got_mx [3];
        logic bad;
        cycles <= cycles + 1;
        if (rst_n && box_valid && !box_stall)
        begin
            got_mn[0] = box_min_x; got_mn[1] = box_min_y; got_mn[2] = box_min_z;
            got_mx[0] = box_max_x; got_mx[1] = box_max_y; got_mx[2] = box_max_z;
            if (pending_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("box word with nothing expected at %0t", $realtime);
            end
            else
            begin
                want = pending_boxes.pop_front();
                bad = (want.last !== last_box);
                for (int j = 0; j < 3; j++)
                    bad = bad || (want.mn[j] !== got_mn[j]) || (want.mx[j] !== got_mx[j]);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("box mismatch: expected min %h %h %h max %h %h %h last %b, got min %h %h %h max %h %h %h last %b",
                            want.mn[0], want.mn[1], want.mn[2], want.mx[0], want.mx[1],
                            want.mx[2], want.last, got_mn[0], got_mn[1], got_mn[2],
                            got_mx[0], got_mx[1], got_mx[2], last_box);
                end
            end
        end
    end

    // Guard against a hung pipeline.
    always @(posedge clk)
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end

    initial
    begin
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corner_splats();
        test_random_splats(500, 0, 0);
        test_random_splats(500, 66, 0);
        test_random_splats(500, 0, 66);
        test_random_splats(500, 32, 32);
        // Let the pipeline drain past its latency to catch stray words.
        repeat (60)
            @(negedge clk);
        if (mismatches == 0 && pending_boxes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
sv/gsbb_pkg.sv
sv/gsbb_front.sv
sv/gsbb_queue.sv
sv/gsbb_back.sv
sv/gaussian_splat_bounding_box.sv
tb/gaussian_splat_bounding_box_test.sv
